### sv/qsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qsb_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_count;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } t_ctl;

    // What a cell shows its neighbors
    typedef struct packed {
        logic  gt;
        t_data value;
    } t_link;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

endpackage
`default_nettype wire

### sv/qsb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module qsb_cell (
    input  wire logic          i_clk,
    input  wire qsb_pkg::t_ctl  i_ctl,
    input  wire qsb_pkg::t_data i_data,
    input  wire logic          i_occupied,
    input  wire qsb_pkg::t_link i_prev,
    input  wire qsb_pkg::t_link i_next,
    output qsb_pkg::t_link      o_link
);

    qsb_pkg::t_data r_value;
    qsb_pkg::t_data n_value;
    logic           w_gt;

    // An empty cell acts as +infinity, so the new word lands at the first
    // cell that holds something larger.
    assign w_gt = !i_occupied || (r_value > i_data);

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.shift) begin
            n_value = i_next.value;
        end else if (i_ctl.insert && i_prev.gt) begin
            n_value = i_prev.value;
        end else if (i_ctl.insert && w_gt) begin
            n_value = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule
`default_nettype wire

### sv/quicksort_batch_sorter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one word per cycle; each word drops straight into its sorted place
// in a row of CAPACITY compare-and-shift cells.
// Emit: the first result shows the cycle after the closing word, then one
// result per cycle while i_out_ready is high, as the row shifts toward cell 0;
// no input is taken while emitting; a word for a full row is dropped (overflow).
// Reset (synchronous, active low) empties the row and clears the overflow flag.
module quicksort_batch_sorter_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [31:0]   i_value,
    input  wire logic                 i_last_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [31:0]        o_sorted_value,
    output logic                      o_last_out,
    output logic                      o_overflow
);

    localparam int N = qsb_pkg::CAPACITY;

    qsb_pkg::t_state r_state, n_state;
    qsb_pkg::t_count r_count, n_count;
    logic            r_ovf, n_ovf;

    logic           w_in_acc;
    logic           w_out_acc;
    logic           w_room;
    qsb_pkg::t_ctl  w_ctl;
    qsb_pkg::t_link w_link [N];
    qsb_pkg::t_link w_edge;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_room    = r_count < qsb_pkg::t_count'(N);

    assign w_ctl.insert = w_in_acc && w_room;
    assign w_ctl.shift  = w_out_acc;

    assign w_edge.gt    = 1'b0;
    assign w_edge.value = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam qsb_pkg::t_count IDX = qsb_pkg::t_count'(g);
        qsb_pkg::t_link w_prev, w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_edge;
        end else begin : g_mid_lo
            assign w_prev = w_link[g-1];
        end
        if (g == N - 1) begin : g_last
            assign w_next = w_edge;
        end else begin : g_mid_hi
            assign w_next = w_link[g+1];
        end
        qsb_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_data     (i_value),
            .i_occupied (IDX < r_count),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_link     (w_link[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        unique case (r_state)
            qsb_pkg::ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + qsb_pkg::t_count'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = qsb_pkg::ST_EMIT;
                    end
                end
            end
            qsb_pkg::ST_EMIT: begin
                if (w_out_acc) begin
                    n_count = r_count - qsb_pkg::t_count'(1);
                    if (o_last_out) begin
                        n_state = qsb_pkg::ST_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = qsb_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qsb_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_in_ready     = (r_state == qsb_pkg::ST_LOAD);
    assign o_out_valid    = (r_state == qsb_pkg::ST_EMIT);
    assign o_sorted_value = w_link[0].value;
    assign o_last_out     = (r_count == qsb_pkg::t_count'(1));
    assign o_overflow     = r_ovf;

endmodule
`default_nettype wire

### sv/qsb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module qsb_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_in_ready,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] o_sorted_value,
    input  wire logic               o_last_out,
    input  wire logic               o_overflow
);

    logic w_out_acc;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while emitting");

    // Results of one batch come out in ascending order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !o_last_out |=> o_out_valid &&
            (o_sorted_value >= $past(o_sorted_value)))
        else $error("results not ascending");

    // Overflow flag is the same on every word of a batch
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !o_last_out |=> o_overflow == $past(o_overflow))
        else $error("overflow flag changed within batch");

    // Closing result reopens the input side
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_last_out |=> o_in_ready && !o_out_valid)
        else $error("input not reopened after batch");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sorted_value)
            && $stable(o_last_out))
        else $error("stalled result changed");

endmodule

bind quicksort_batch_sorter_unit qsb_checker u_qsb_checker (.*);
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 2 * qsb_pkg::CAPACITY + 16;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_WORDS = 300;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EDGES
    } t_value_mix;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               ovf;
    } t_sorted_word;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic signed [31:0] i_value     = '0;
    logic               i_last_in   = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_sorted_value;
    logic               o_last_out;
    logic               o_overflow;

    // Predictor copy of the batch being collected
    logic signed [31:0] batch_store [qsb_pkg::CAPACITY];
    int                 batch_fill    = 0;
    bit                 batch_dropped = 1'b0;
    t_sorted_word       pending_sorted [$];

    int  send_gap_max  = 15;
    int  recv_gap_max  = 15;
    bit  hold_req      = 1'b0;
    int  holds_done    = 0;
    int  cycle_count   = 0;
    int  mismatches    = 0;
    int  words_sent    = 0;
    int  batches_sent  = 0;
    int  ovf_batches   = 0;
    int  results_seen  = 0;

    quicksort_batch_sorter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_sorted.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Quicksort with first-element pivot and an explicit range stack
    task automatic batch_sort_predict(input logic signed [31:0] v, input logic l);
        int                 range_start [$];
        int                 range_len [$];
        int                 s, n, lo, hi;
        logic signed [31:0] piv, cur, spare;
        bit                 open;
        t_sorted_word       w;
        if (batch_fill < qsb_pkg::CAPACITY) begin
            batch_store[batch_fill] = v;
            batch_fill++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (!l) return;
        if (batch_fill >= 2) begin
            range_start.push_back(0);
            range_len.push_back(batch_fill);
        end
        while (range_start.size() > 0) begin
            s    = range_start.pop_back();
            n    = range_len.pop_back();
            piv  = batch_store[s];
            lo   = 1;
            hi   = n - 1;
            cur  = batch_store[s + 1];
            open = 1'b1;
            while (open) begin
                if (cur < piv) begin
                    batch_store[s + lo - 1] = cur;
                    lo++;
                    if (lo <= hi) cur = batch_store[s + lo];
                    else open = 1'b0;
                end else begin
                    spare = batch_store[s + hi];
                    batch_store[s + hi] = cur;
                    cur = spare;
                    if (hi == lo) open = 1'b0;
                    hi--;
                end
            end
            batch_store[s + lo - 1] = piv;
            if (hi > 1) begin
                range_start.push_back(s);
                range_len.push_back(hi);
            end
            if (lo + 1 < n) begin
                range_start.push_back(s + lo);
                range_len.push_back(n - lo);
            end
        end
        for (int k = 0; k < batch_fill; k++) begin
            w.value = batch_store[k];
            w.last  = (k + 1 == batch_fill);
            w.ovf   = batch_dropped;
            pending_sorted.push_back(w);
        end
        batches_sent++;
        if (batch_dropped) ovf_batches++;
        batch_fill    = 0;
        batch_dropped = 1'b0;
    endtask

    task automatic send_word(input logic signed [31:0] v, input logic l);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last_in  <= l;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        batch_sort_predict(v, l);
    endtask

    task automatic send_batch(input int len, input t_value_mix mix);
        logic signed [31:0] v;
        for (int k = 0; k < len; k++) begin
            case (mix)
                MIX_NARROW: v = $signed($urandom_range(0, 6)) - 3;
                MIX_EDGES: begin
                    case ($urandom_range(0, 5))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = 0;
                        3: v = -1;
                        4: v = 1;
                        default: v = $urandom;
                    endcase
                end
                default: v = $urandom;
            endcase
            send_word(v, k == len - 1);
        end
    endtask

    // Hold the input side until every expected word has come back
    task automatic wait_all_sorted();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sorted.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(5, 1'b1);
        send_word(VAL_MAX, 1'b0);
        send_word(VAL_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b1);
        send_word(7, 1'b0);
        send_word(7, 1'b0);
        send_word(-7, 1'b0);
        send_word(7, 1'b1);
        for (int k = -3; k <= 1; k++) send_word(k, k == 1);
        for (int k = 3; k >= -2; k--) send_word(k, k == -2);
        send_word(VAL_MIN, 1'b0);
        send_word(VAL_MIN, 1'b1);
    endtask

    // Full store, closing word dropped, and several extra words dropped
    task automatic test_capacity();
        send_batch(qsb_pkg::CAPACITY, MIX_WIDE);
        send_batch(qsb_pkg::CAPACITY + 1, MIX_EDGES);
        send_batch(qsb_pkg::CAPACITY + 6, MIX_NARROW);
    endtask

    task automatic test_random();
        int start_words, len, r;
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            r = $urandom_range(0, 99);
            if (r < 60)      len = $urandom_range(1, 12);
            else if (r < 85) len = $urandom_range(13, 40);
            else if (r < 95) len = $urandom_range(41, qsb_pkg::CAPACITY);
            else len = $urandom_range(qsb_pkg::CAPACITY + 1, qsb_pkg::CAPACITY + 8);
            send_batch(len, t_value_mix'($urandom_range(0, 2)));
        end
        send_gap_max = 15;
        recv_gap_max = 15;
    endtask

    // Stall the result side mid-batch while new words keep coming
    task automatic test_backpressure();
        send_gap_max = 0;
        hold_req     = 1'b1;
        send_batch(20, MIX_WIDE);
        send_batch(20, MIX_NARROW);
        send_gap_max = 15;
    endtask

    initial begin : result_checker
        int           gap;
        t_sorted_word want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_seen++;
            if (pending_sorted.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: value %0d last %b ovf %b",
                             o_sorted_value, o_last_out, o_overflow);
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_value !== want.value || o_last_out !== want.last ||
                    o_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d: expected %0d/%b/%b got %0d/%b/%b",
                                 results_seen, want.value, want.last, want.ovf,
                                 o_sorted_value, o_last_out, o_overflow);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_all_sorted();
        test_capacity();
        wait_all_sorted();
        test_random();
        test_backpressure();
        wait_all_sorted();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_sorted.size() != 0) begin
            mismatches++;
            $display("%0d expected words never arrived", pending_sorted.size());
        end
        $display("sent %0d words in %0d batches (%0d with dropped words)",
                 words_sent, batches_sent, ovf_batches);
        $display("checked %0d results, long output stalls: %0d, mismatches: %0d",
                 results_seen, holds_done, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
